FILE: hw/rtl/ttlc_pkg.sv
`default_nettype none

package ttlc_pkg;

    // table geometry and field widths
    localparam int DEPTH      = 16;
    localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int TIME_BITS  = 32;
    localparam int TTL_BITS   = 16;
    localparam int CNT_BITS   = 5;
    localparam int CAP_BITS   = 5;
    localparam int REQ_BITS   = 2;

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_STORE  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

    // configuration register addresses
    localparam logic ADDR_CAPACITY = 1'b0;

    // request tdata layout
    localparam int IN_KEY_LSB   = 0;
    localparam int IN_VALUE_LSB = IN_KEY_LSB + KEY_BITS;
    localparam int IN_NOW_LSB   = IN_VALUE_LSB + VALUE_BITS;
    localparam int IN_TTL_LSB   = IN_NOW_LSB + TIME_BITS;
    localparam int IN_USED_BITS = IN_TTL_LSB + TTL_BITS;
    localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

    // result tdata layout
    localparam int OUT_VALUE_LSB = 0;
    localparam int OUT_CNT_LSB   = OUT_VALUE_LSB + VALUE_BITS;
    localparam int OUT_USED_BITS = OUT_CNT_LSB + CNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

FILE: hw/rtl/ttl_cache_oldest_eviction_unit.sv
`default_nettype none

// Keyed cache of DEPTH entries with per-entry expiry and oldest-first eviction.
// Each request on the slave stream carries a kind in tuser (lookup, store,
// clear) and key, value, now and ttl in tdata; each request yields exactly one
// result on the master stream: a hit flag in tuser, the hit value and the entry
// count in tdata. A lookup drops an entry found at or past its expiry instead
// of returning it. A store with a nonzero ttl first drops every expired entry,
// evicts the entry inserted longest ago (lowest slot on a tie) when the key is
// new and the table holds capacity entries, then writes the key with expiry
// now + ttl, saturated at the time maximum. One request is worked on at a
// time and tready is low meanwhile. A single compare unit walks the table one
// slot per cycle. A store walks every slot, then decides and writes its
// slot, then places its result; a lookup ends its walk at the first key
// match or after the last slot; a clear, an unknown request kind or a store
// with zero ttl skips the walk and goes straight to the result state. A result
// still held in the output register stalls the block until the master side
// takes it. The capacity register lies at byte address 0 of the APB port; 0
// acts as 1 and values above DEPTH act as DEPTH. Write it only while the
// block is idle.
module ttl_cache_oldest_eviction_unit (
    input  wire  logic                                 i_clk,
    input  wire  logic                                 i_rst_n,
    // request stream
    input  wire  logic                                 i_s_tvalid,
    output logic                                       o_s_tready,
    // key [63:0], value [127:64], now [159:128], ttl [175:160]
    input  wire  logic [ttlc_pkg::IN_DATA_BITS-1:0]    i_s_tdata,
    // req_type [1:0]
    input  wire  logic [ttlc_pkg::REQ_BITS-1:0]        i_s_tuser,
    // result stream
    output logic                                       o_m_tvalid,
    input  wire  logic                                 i_m_tready,
    // hit_value [63:0], entry_count [68:64], zero above
    output logic [ttlc_pkg::OUT_DATA_BITS-1:0]         o_m_tdata,
    // hit [0]
    output logic                                       o_m_tuser,
    // configuration port
    input  wire  logic                                 psel,
    input  wire  logic                                 penable,
    input  wire  logic                                 pwrite,
    input  wire  logic                                 paddr,
    input  wire  logic [31:0]                          pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    localparam int D  = ttlc_pkg::DEPTH;
    localparam int IB = ttlc_pkg::IDX_BITS;
    localparam int KB = ttlc_pkg::KEY_BITS;
    localparam int VB = ttlc_pkg::VALUE_BITS;
    localparam int TB = ttlc_pkg::TIME_BITS;
    localparam int WB = ttlc_pkg::TTL_BITS;
    localparam int CB = ttlc_pkg::CNT_BITS;
    localparam int AB = ttlc_pkg::CAP_BITS;
    localparam int RB = ttlc_pkg::REQ_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT
    } t_state;

    t_state r_state;

    // configuration
    logic [AB-1:0] r_capacity;

    // slot storage: valid bits and count are control, the rest is payload
    logic [D-1:0]  r_valid;
    logic [CB-1:0] r_count;
    logic [KB-1:0] r_slot_key      [D];
    logic [VB-1:0] r_slot_value    [D];
    logic [TB-1:0] r_slot_expiry   [D];
    logic [TB-1:0] r_slot_inserted [D];

    // captured request
    logic [RB-1:0] r_req;
    logic [KB-1:0] r_key;
    logic [VB-1:0] r_value;
    logic [TB-1:0] r_now;
    logic [WB-1:0] r_ttl;

    // scan bookkeeping
    logic [IB-1:0] r_idx;
    logic          r_found;
    logic [IB-1:0] r_found_idx;
    logic          r_free_ok;
    logic [IB-1:0] r_free_idx;
    logic          r_old_ok;
    logic [IB-1:0] r_old_idx;
    logic [TB-1:0] r_old_ins;

    // per-request result
    logic          r_hit;
    logic [VB-1:0] r_hit_value;

    // output register
    logic          r_m_valid;
    logic          r_m_hit;
    logic [VB-1:0] r_m_value;
    logic [CB-1:0] r_m_count;

    // shared slot compare unit, looks at the slot under r_idx
    logic          s_valid;
    logic          s_expired;
    logic          s_live;
    logic          s_match;
    logic          s_older;
    logic          s_last;

    assign s_valid   = r_valid[r_idx];
    assign s_expired = s_valid && (r_now >= r_slot_expiry[r_idx]);
    assign s_live    = s_valid && !s_expired;
    assign s_match   = s_valid && (r_slot_key[r_idx] == r_key);
    assign s_older   = !r_old_ok || (r_slot_inserted[r_idx] < r_old_ins);
    assign s_last    = (r_idx == IB'(D - 1));

    // store decision
    logic [CB-1:0] n_eff_cap;
    logic          n_evict;
    logic [IB-1:0] n_tgt;
    logic [TB:0]   n_sum;
    logic [TB-1:0] n_expiry;
    logic [D-1:0]  n_valid;

    always_comb begin
        if (r_capacity == '0) begin
            n_eff_cap = CB'(1);
        end else if (CB'(r_capacity) > CB'(D)) begin
            n_eff_cap = CB'(D);
        end else begin
            n_eff_cap = CB'(r_capacity);
        end
        n_evict = !r_found && (r_count >= n_eff_cap);
        if (r_found) begin
            n_tgt = r_found_idx;
        end else if (n_evict) begin
            // the evicted slot competes with the lowest free slot
            n_tgt = (r_free_ok && (r_free_idx < r_old_idx)) ? r_free_idx : r_old_idx;
        end else begin
            n_tgt = r_free_idx;
        end
        // valid bits after a store of a new key
        n_valid = r_valid;
        if (n_evict) begin
            n_valid[r_old_idx] = 1'b0;
        end
        n_valid[n_tgt] = 1'b1;
        n_sum    = {1'b0, r_now} + (TB + 1)'(r_ttl);
        n_expiry = n_sum[TB] ? {TB{1'b1}} : n_sum[TB-1:0];
    end

    logic in_fire;
    assign in_fire = i_s_tvalid && o_s_tready;

    // control, valid bits and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_capacity <= AB'(D);
            r_valid    <= '0;
            r_count    <= '0;
            r_m_valid  <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == ttlc_pkg::ADDR_CAPACITY) begin
                r_capacity <= pwdata[AB-1:0];
            end
            if (i_m_tready && r_state != ST_RESULT) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_req       <= i_s_tuser;
                        r_key       <= i_s_tdata[ttlc_pkg::IN_KEY_LSB +: KB];
                        r_value     <= i_s_tdata[ttlc_pkg::IN_VALUE_LSB +: VB];
                        r_now       <= i_s_tdata[ttlc_pkg::IN_NOW_LSB +: TB];
                        r_ttl       <= i_s_tdata[ttlc_pkg::IN_TTL_LSB +: WB];
                        r_idx       <= '0;
                        r_found     <= 1'b0;
                        r_free_ok   <= 1'b0;
                        r_old_ok    <= 1'b0;
                        r_hit       <= 1'b0;
                        r_hit_value <= '0;
                        if (i_s_tuser == ttlc_pkg::REQ_LOOKUP) begin
                            r_state <= ST_SCAN;
                        end else if (i_s_tuser == ttlc_pkg::REQ_STORE &&
                                     i_s_tdata[ttlc_pkg::IN_TTL_LSB +: WB] != '0) begin
                            r_state <= ST_SCAN;
                        end else begin
                            if (i_s_tuser == ttlc_pkg::REQ_CLEAR) begin
                                r_valid <= '0;
                                r_count <= '0;
                            end
                            r_state <= ST_RESULT;
                        end
                    end
                end

                ST_SCAN: begin
                    r_idx <= r_idx + IB'(1);
                    if (r_req == ttlc_pkg::REQ_LOOKUP) begin
                        // keys are unique, so the first match ends the walk
                        if (s_match) begin
                            if (s_expired) begin
                                r_valid[r_idx] <= 1'b0;
                                r_count        <= r_count - CB'(1);
                            end else begin
                                r_hit       <= 1'b1;
                                r_hit_value <= r_slot_value[r_idx];
                            end
                            r_state <= ST_RESULT;
                        end else if (s_last) begin
                            r_state <= ST_RESULT;
                        end
                    end else begin
                        // prune, find key, track oldest live and lowest free
                        if (s_expired) begin
                            r_valid[r_idx] <= 1'b0;
                            r_count        <= r_count - CB'(1);
                        end
                        if (s_live && s_match) begin
                            r_found     <= 1'b1;
                            r_found_idx <= r_idx;
                        end
                        if (s_live && s_older) begin
                            r_old_ok  <= 1'b1;
                            r_old_idx <= r_idx;
                            r_old_ins <= r_slot_inserted[r_idx];
                        end
                        if (!s_live && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_idx;
                        end
                        if (s_last) begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end

                ST_DECIDE: begin
                    if (!r_found) begin
                        // one out, one in: count holds on an eviction
                        if (!n_evict) begin
                            r_count <= r_count + CB'(1);
                        end
                        r_valid <= n_valid;
                    end
                    r_state <= ST_RESULT;
                end

                ST_RESULT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_hit   <= r_hit;
                        r_m_value <= r_hit_value;
                        r_m_count <= r_count;
                        r_state   <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // slot payload, written once per store
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE) begin
            if (!r_found) begin
                r_slot_key[n_tgt] <= r_key;
            end
            r_slot_value[n_tgt]    <= r_value;
            r_slot_expiry[n_tgt]   <= n_expiry;
            r_slot_inserted[n_tgt] <= r_now;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_hit;
    assign o_m_tdata  = {{(ttlc_pkg::OUT_DATA_BITS - ttlc_pkg::OUT_USED_BITS){1'b0}},
                         r_m_count, r_m_value};

    assign pready = 1'b1;
    assign prdata = (paddr == ttlc_pkg::ADDR_CAPACITY) ? {{(32 - AB){1'b0}}, r_capacity}
                                                       : 32'd0;

    // count tracks the valid bits at all times
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CB'($countones(r_valid)))
        else $error("entry count out of step with valid bits");

    // the table never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(D))
        else $error("entry count above table depth");

    // only a lookup can produce a hit
    a_hit_only_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && r_req != ttlc_pkg::REQ_LOOKUP) |-> !r_hit)
        else $error("hit flagged on a non-lookup request");

    // a store of a new key always finds a slot
    a_store_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && !r_found) |-> (r_free_ok || (n_evict && r_old_ok)))
        else $error("store with no slot to write");

endmodule

`default_nettype wire
